@@ hw/rtl/bqrm_pkg.sv @@
package bqrm_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int WORD_W = 32;
   localparam int CAP_W  = 5;
   localparam int OCC_W  = 5;
   localparam int OP_W   = 2;
   localparam int RES_W  = WORD_W + 2 + 1 + OCC_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_ROTATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_ROT_END,
      ST_HOLD
   } state_type;

   // Packed from the top down, so data_out lands in the lowest bits.
   typedef struct packed {
      logic [OCC_W-1:0] occupancy;
      logic             dropped;
      status_type       status;
      word_type         data_out;
   } res_type;

   typedef struct packed {
      logic    step;
      logic    first;
      cnt_type offset;
   } scan_ctl_type;

   // A head plus an offset never reaches twice the depth, so one subtract wraps it.
   function automatic idx_type wrap_slot(logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] s;
      s = sum;
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

@@ hw/rtl/bqrm_ram.sv @@
module bqrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bqrm_scan.sv @@
module bqrm_scan
   import bqrm_pkg::*;
(
   input  logic         clock,
   input  scan_ctl_type ctl,
   input  word_type     data,
   output cnt_type      best_off
);

   word_type best_val_ff, best_val_in;
   cnt_type  best_off_ff, best_off_in;

   // Strictly greater, so the first of equal maxima from the head is kept.
   always_comb begin
      best_val_in = best_val_ff;
      best_off_in = best_off_ff;
      if (ctl.step) begin
         if (ctl.first || ($signed(data) > $signed(best_val_ff))) begin
            best_val_in = data;
            best_off_in = ctl.offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff <= best_val_in;
      best_off_ff <= best_off_in;
   end

   assign best_off = best_off_ff;

endmodule

@@ hw/rtl/bounded_queue_rotate_to_max_unit.sv @@
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tuser op, tdata value
// rsp       out        rsp_tvalid/rsp_tready   tdata data_out,status,dropped,occupancy
// csr       in         csr_valid/csr_ready     csr_data capacity
//
// Push, clear, a zero push and operations on an empty queue complete on acceptance.
// Pop goes through ST_POP: the entry comes through the registered read of the RAM.
// Rotate passes through ST_SCAN, where the RAM port reads one entry per cycle
// into the signed compare unit, then ST_ROT_END moves the head to the winner.
// Reset is synchronous; the entry RAM is not cleared and needs no sweep.
// A result that is not taken waits in a holding register and stops new requests.
module bounded_queue_rotate_to_max_unit
   import bqrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [OP_W-1:0]   req_tuser,   // [1:0] op
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] value
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RES_W-1:0]  rsp_tdata,   // [31:0] data_out, [33:32] status,
                                          // [34] dropped, [39:35] occupancy
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data
);

   state_type state_ff, state_in;

   idx_type          head_ff, head_in;
   cnt_type          count_ff, count_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   cnt_type          scan_off_ff, scan_off_in;
   cnt_type          rd_off_ff, rd_off_in;
   res_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          hold_ff, hold_in;

   logic         req_fire;
   logic         out_free;
   op_type       op;
   cnt_type      cap_eff;
   cnt_type      drop_cnt;
   idx_type      push_head;
   cnt_type      push_count;
   logic         fin;
   res_type      fin_res;
   logic         scan_last;

   logic         ram_wr_en;
   idx_type      ram_wr_addr;
   logic         ram_rd_en;
   idx_type      ram_rd_addr;
   word_type     ram_rd_data;
   scan_ctl_type scan_ctl;
   cnt_type      best_off;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign op         = op_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign scan_last  = (rd_off_ff == (count_ff - CNT_W'(1)));

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   // When full (or capacity was lowered), enough of the oldest entries go so
   // that the push leaves exactly capacity entries.
   always_comb begin
      drop_cnt   = count_ff - cap_eff + CNT_W'(1);
      push_head  = head_ff;
      push_count = count_ff;
      if (count_ff >= cap_eff) begin
         push_head  = wrap_slot(SUM_W'(head_ff) + SUM_W'(drop_cnt));
         push_count = cap_eff - CNT_W'(1);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((op == OP_POP) && (count_ff != '0)) begin
                  state_in = ST_POP;
               end else if ((op == OP_ROTATE) && (count_ff != '0)) begin
                  state_in = ST_SCAN;
               end else if (!out_free) begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_POP, ST_ROT_END, ST_HOLD: begin
            state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_ROT_END;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      scan_off_in  = scan_off_ff;
      rd_off_in    = rd_off_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hold_in      = hold_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;
      scan_ctl     = '0;
      fin          = 1'b0;
      fin_res      = '0;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (op)
                  OP_PUSH: begin
                     fin = 1'b1;
                     if (req_tdata == '0) begin
                        fin_res.status    = STATUS_INVALID;
                        fin_res.occupancy = OCC_W'(count_ff);
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wrap_slot(SUM_W'(push_head) + SUM_W'(push_count));
                        head_in     = push_head;
                        count_in    = push_count + CNT_W'(1);
                        fin_res.dropped   = (count_ff >= cap_eff);
                        fin_res.occupancy = OCC_W'(push_count + CNT_W'(1));
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        fin               = 1'b1;
                        fin_res.status    = STATUS_EMPTY;
                        fin_res.occupancy = '0;
                     end else begin
                        ram_rd_en = 1'b1;
                        count_in  = count_ff - CNT_W'(1);
                        head_in   = (count_ff == CNT_W'(1)) ? '0 :
                                    wrap_slot(SUM_W'(head_ff) + SUM_W'(1));
                     end
                  end
                  OP_CLEAR: begin
                     fin               = 1'b1;
                     head_in           = '0;
                     count_in          = '0;
                     fin_res.occupancy = '0;
                  end
                  OP_ROTATE: begin
                     if (count_ff == '0) begin
                        fin               = 1'b1;
                        fin_res.status    = STATUS_EMPTY;
                        fin_res.occupancy = '0;
                     end else begin
                        ram_rd_en   = 1'b1;
                        scan_off_in = CNT_W'(1);
                        rd_off_in   = '0;
                     end
                  end
                  default: begin
                     fin = 1'b0;
                  end
               endcase
            end
         end
         ST_POP: begin
            fin               = 1'b1;
            fin_res.data_out  = ram_rd_data;
            fin_res.occupancy = OCC_W'(count_ff);
         end
         ST_SCAN: begin
            // Reads run one entry ahead of the compare.
            scan_ctl.step   = 1'b1;
            scan_ctl.first  = (rd_off_ff == '0);
            scan_ctl.offset = rd_off_ff;
            if (scan_off_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = wrap_slot(SUM_W'(head_ff) + SUM_W'(scan_off_ff));
               scan_off_in = scan_off_ff + CNT_W'(1);
            end
            rd_off_in = rd_off_ff + CNT_W'(1);
         end
         ST_ROT_END: begin
            fin               = 1'b1;
            head_in           = wrap_slot(SUM_W'(head_ff) + SUM_W'(best_off));
            fin_res.occupancy = OCC_W'(count_ff);
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            fin = 1'b0;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_in       = fin_res;
            rsp_valid_in = 1'b1;
         end else begin
            hold_in = fin_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_off_ff <= scan_off_in;
      rd_off_ff   <= rd_off_in;
      rsp_ff      <= rsp_in;
      hold_ff     <= hold_in;
   end

   bqrm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_tdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bqrm_scan u_scan (
      .clock    (clock),
      .ctl      (scan_ctl),
      .data     (ram_rd_data),
      .best_off (best_off)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= DEPTH)
      else $error("entry count exceeds the depth");

   a_push_fills : assert property (@(posedge clock) disable iff (reset)
      (req_fire && (op == OP_PUSH) && (req_tdata != '0)) |=> (count_ff != '0))
      else $error("valid push left the queue empty");

   a_hold_blocked : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("held result without a pending output");

   a_scan_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_off_ff < count_ff))
      else $error("scan offset ran past the occupancy");

endmodule

@@ sim/tb_bounded_queue_rotate_to_max_unit.sv @@
`timescale 1ns / 100ps

module tb_bounded_queue_rotate_to_max_unit;
   import bqrm_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [OP_W-1:0]   req_tuser;   // [1:0] op
   logic [WORD_W-1:0] req_tdata;   // [31:0] value
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RES_W-1:0]  rsp_tdata;   // [31:0] data_out, [33:32] status,
                                   // [34] dropped, [39:35] occupancy
   logic              csr_valid;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data;

   // Queue predictor state.
   word_type         ring [DEPTH];
   idx_type          head_pos;
   cnt_type          fill;
   logic [CAP_W-1:0] cap_reg;

   res_type pending_results [$];

   int mismatch_count;
   int rsp_count;
   int push_count, pop_count, clear_count, rotate_count, drop_count;
   int settings_count;
   bit req_idle_on;
   bit rsp_idle_on;
   int rsp_stall_left;

   bounded_queue_rotate_to_max_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      // Small values make equal maxima and zero pushes common.
      if (r < 30) return word_type'(int'($urandom_range(0, 8)) - 4);
      if (r < 40) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0001;
         endcase
      end
      return $urandom;
   endfunction

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return OP_PUSH;
      if (r < 75) return OP_POP;
      if (r < 95) return OP_ROTATE;
      return OP_CLEAR;
   endfunction

   function automatic idx_type ring_slot(int offset);
      return idx_type'((int'(head_pos) + offset) % DEPTH);
   endfunction

   function automatic res_type model_queue_step(op_type op, word_type value);
      res_type r;
      int lim;
      int drop;
      int best;
      int i;
      r = '0;
      lim = int'(cap_reg);
      if (lim == 0) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      case (op)
         OP_PUSH: begin
            push_count++;
            if (value == '0) begin
               r.status = STATUS_INVALID;
            end else begin
               if (int'(fill) >= lim) begin
                  drop = int'(fill) - lim + 1;
                  head_pos = ring_slot(drop);
                  fill = cnt_type'(int'(fill) - drop);
                  r.dropped = 1'b1;
                  drop_count++;
               end
               ring[ring_slot(int'(fill))] = value;
               fill = fill + 1'b1;
            end
         end
         OP_POP: begin
            pop_count++;
            if (fill == '0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.data_out = ring[head_pos];
               fill = fill - 1'b1;
               head_pos = (fill == '0) ? idx_type'(0) : ring_slot(1);
            end
         end
         OP_CLEAR: begin
            clear_count++;
            head_pos = '0;
            fill = '0;
         end
         default: begin
            rotate_count++;
            if (fill == '0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = 0;
               for (i = 1; i < int'(fill); i++) begin
                  if ($signed(ring[ring_slot(i)]) > $signed(ring[ring_slot(best)])) begin
                     best = i;
                  end
               end
               head_pos = ring_slot(best);
            end
         end
      endcase
      r.occupancy = OCC_W'(fill);
      return r;
   endfunction

   // Valid stays high from one request to the next unless a gap is taken.
   task automatic issue_request(input op_type op, input word_type value);
      int gap;
      gap = req_idle_on ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(model_queue_step(op, value));
   endtask

   task automatic wait_queue_idle(input int limit);
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && waited < limit) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      cap_reg = cap;
      settings_count++;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (rsp_stall_left == 0 && rsp_idle_on) rsp_stall_left = gap_length();
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      res_type want;
      res_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         got = res_type'(rsp_tdata);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, data_out %0d status %0d dropped %0d occupancy %0d",
                     $time, $signed(got.data_out), got.status, got.dropped, got.occupancy);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.data_out !== want.data_out) begin
               $display("%0t: data_out expected %0d, got %0d", $time,
                        $signed(want.data_out), $signed(got.data_out));
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
               mismatch_count++;
            end
            if (got.dropped !== want.dropped) begin
               $display("%0t: dropped expected %0d, got %0d", $time, want.dropped, got.dropped);
               mismatch_count++;
            end
            if (got.occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d, got %0d", $time,
                        want.occupancy, got.occupancy);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_empty_and_invalid();
      issue_request(OP_POP, 32'h0);
      issue_request(OP_ROTATE, 32'h0);
      issue_request(OP_PUSH, 32'h0);
      issue_request(OP_CLEAR, 32'hdead_beef);
      issue_request(OP_PUSH, 32'd9);
      // This pop empties the queue, so the head pointer goes back to zero.
      issue_request(OP_POP, 32'h0);
      issue_request(OP_PUSH, 32'd7);
      issue_request(OP_PUSH, 32'h0);
      issue_request(OP_POP, 32'hffff_ffff);
   endtask

   task automatic test_signed_rotate();
      issue_request(OP_PUSH, 32'h8000_0000);
      issue_request(OP_PUSH, 32'hffff_ffff);
      issue_request(OP_PUSH, 32'h0000_0001);
      issue_request(OP_PUSH, 32'h7fff_ffff);
      issue_request(OP_PUSH, 32'd3);
      issue_request(OP_PUSH, 32'h7fff_ffff);
      issue_request(OP_ROTATE, 32'h0);
      // The head already holds the first of two equal maxima, so nothing moves.
      issue_request(OP_ROTATE, 32'h0);
      issue_request(OP_POP, 32'h0);
      issue_request(OP_ROTATE, 32'h0);
      issue_request(OP_POP, 32'h0);
      issue_request(OP_CLEAR, 32'h0);
   endtask

   task automatic test_capacity_shrink();
      int i;
      for (i = 0; i < 6; i++) issue_request(OP_PUSH, pick_value() | 32'h100);
      wait_queue_idle(20000);
      // Capacity now below the count: one push drops enough to land on two.
      write_capacity(5'd2);
      issue_request(OP_PUSH, 32'h1234_5678);
      issue_request(OP_POP, 32'h0);
      wait_queue_idle(20000);
      write_capacity(5'd0);
      issue_request(OP_PUSH, 32'd11);
      issue_request(OP_PUSH, 32'd12);
      issue_request(OP_POP, 32'h0);
   endtask

   task automatic test_random_phases();
      logic [CAP_W-1:0] caps [10];
      int p;
      int n;
      caps = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd8, 5'd17,
               5'($urandom_range(0, 31)), 5'($urandom_range(1, 16)), 5'd16};
      for (p = 0; p < 10; p++) begin
         wait_queue_idle(20000);
         write_capacity(caps[p]);
         // Two phases run with no idling on either side.
         req_idle_on = (p != 0 && p != 5);
         rsp_idle_on = (p != 0 && p != 5);
         for (n = 0; n < 145; n++) issue_request(pick_op(), pick_value());
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      head_pos = '0;
      fill     = '0;
      cap_reg  = CAP_RESET;
      rsp_stall_left = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_invalid();
      test_signed_rotate();
      test_capacity_shrink();
      test_random_phases();

      wait_queue_idle(20000);
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         mismatch_count += pending_results.size();
      end
      $display("Checked %0d results: %0d pushes, %0d pops, %0d rotates, %0d clears.",
               rsp_count, push_count, pop_count, rotate_count, clear_count);
      $display("Saw %0d overflow drops across %0d capacity settings; %0d mismatches.",
               drop_count, settings_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("%0t: run timed out", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule
